// File: hw/rtl/ffs_pkg.sv
// package for the fastx fragment scanner: character codes, class codes,
// register indexes, result beat layout and the byte classifier
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ffs_pkg;

  localparam int DEF_COUNT_BITS      = 32;
  localparam int DEF_BASE_COUNT_BITS = 40;

  localparam int BYTE_W    = 8;
  localparam int LPR_W     = 3;
  localparam int MINLEN_W  = 16;
  localparam int CLASS_W   = 3;
  localparam int INDEX_W   = 32;
  localparam int TOTAL_W   = 32;
  localparam int BTOTAL_W  = 40;
  localparam int LONGEST_W = 33;
  localparam int CFG_IDX_W = 1;

  // out tdata: packed result fields, padded to whole bytes
  localparam int OUT_FIELDS_W = INDEX_W + CLASS_W + 3 * TOTAL_W + 2 * BTOTAL_W + LONGEST_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

  localparam logic [CFG_IDX_W-1:0] CFG_LINES_PER_RECORD    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAGMENT_LENGTH = 1'd1;

  localparam logic [LPR_W-1:0]    LPR_RESET    = 3'd2;
  localparam logic [LPR_W-1:0]    LPR_MIN      = 3'd2;
  localparam logic [LPR_W-1:0]    LPR_MAX      = 3'd4;
  localparam logic [MINLEN_W-1:0] MINLEN_RESET = 16'd1;

  localparam logic [BYTE_W-1:0] CHAR_UA = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_UC = 8'h43;
  localparam logic [BYTE_W-1:0] CHAR_UG = 8'h47;
  localparam logic [BYTE_W-1:0] CHAR_UT = 8'h54;
  localparam logic [BYTE_W-1:0] CHAR_LA = 8'h61;
  localparam logic [BYTE_W-1:0] CHAR_LC = 8'h63;
  localparam logic [BYTE_W-1:0] CHAR_LG = 8'h67;
  localparam logic [BYTE_W-1:0] CHAR_LT = 8'h74;
  localparam logic [BYTE_W-1:0] CHAR_DOT     = 8'h2e;
  localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0a;

  localparam logic [CLASS_W-1:0] CLASS_TERM = 3'd0;
  localparam logic [CLASS_W-1:0] CLASS_A    = 3'd1;
  localparam logic [CLASS_W-1:0] CLASS_C    = 3'd2;
  localparam logic [CLASS_W-1:0] CLASS_G    = 3'd3;
  localparam logic [CLASS_W-1:0] CLASS_T    = 3'd4;

  typedef struct packed {
    logic               hit;
    logic [CLASS_W-1:0] cls;
  } ffs_class_t;

  typedef struct packed {
    logic                 write_valid;
    logic [INDEX_W-1:0]   write_index;
    logic [CLASS_W-1:0]   write_class;
    logic [TOTAL_W-1:0]   read_total;
    logic [TOTAL_W-1:0]   useful_read_total;
    logic [TOTAL_W-1:0]   fragment_total;
    logic [BTOTAL_W-1:0]  useable_base_total;
    logic [BTOTAL_W-1:0]  base_total;
    logic [LONGEST_W-1:0] longest_plus_one;
  } ffs_result_t;

  function automatic ffs_class_t class_of(input logic [BYTE_W-1:0] b);
    ffs_class_t c;
    c.hit = 1'b1;
    c.cls = CLASS_TERM;
    case (b)
      CHAR_UA, CHAR_LA: c.cls = CLASS_A;
      CHAR_UC, CHAR_LC: c.cls = CLASS_C;
      CHAR_UG, CHAR_LG: c.cls = CLASS_G;
      CHAR_UT, CHAR_LT: c.cls = CLASS_T;
      CHAR_DOT:         c.cls = CLASS_TERM;
      default:          c.hit = 1'b0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ffs_engine.sv
// scanner state and per-byte update: line phase, fragment tracking,
// store pointer and saturating totals; result of the current byte
// depends on ffs_pkg
`timescale 1ns / 1ps
`default_nettype none

module ffs_engine #(
  parameter int COUNT_BITS      = ffs_pkg::DEF_COUNT_BITS,
  parameter int BASE_COUNT_BITS = ffs_pkg::DEF_BASE_COUNT_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          step_en,
  input  wire logic [ffs_pkg::BYTE_W-1:0]    file_byte,
  input  wire logic [ffs_pkg::LPR_W-1:0]     lines_per_record,
  input  wire logic [ffs_pkg::MINLEN_W-1:0]  min_fragment_length,
  output ffs_pkg::ffs_result_t               result
);
  import ffs_pkg::*;

  localparam int CB = COUNT_BITS;
  localparam int BB = BASE_COUNT_BITS;
  localparam int SUM_W = ((CB > BB) ? CB : BB) + 1;
  localparam logic [CB-1:0] CTOP = {CB{1'b1}};
  localparam logic [BB-1:0] BTOP = {BB{1'b1}};

  logic [1:0]    line_phase_r,    line_phase_nxt;
  logic [CB-1:0] frag_len_r,      frag_len_nxt;
  logic [CB-1:0] line_len_r,      line_len_nxt;
  logic          line_kept_r,     line_kept_nxt;
  logic [CB-1:0] store_ptr_r,     store_ptr_nxt;
  logic [CB-1:0] reads_r,         reads_nxt;
  logic [CB-1:0] useful_r,        useful_nxt;
  logic [CB-1:0] frags_r,         frags_nxt;
  logic [BB-1:0] kept_bases_r,    kept_bases_nxt;
  logic [BB-1:0] line_bases_r,    line_bases_nxt;
  logic [CB-1:0] longest_r,       longest_nxt;

  ffs_class_t         cls;
  logic               newline;
  logic               seq_line;
  logic               keep;
  logic               kept_now;
  logic [LPR_W-1:0]   per;
  logic [LPR_W-1:0]   phase_inc;
  logic [SUM_W-1:0]   kept_sum;
  logic [SUM_W-1:0]   line_sum;
  logic [CB:0]        longest_inc;

  always_comb begin
    cls      = class_of(file_byte);
    newline  = (file_byte == CHAR_NEWLINE);
    seq_line = (line_phase_r == 2'd1);
    keep     = !cls.hit && (frag_len_r >= CB'(min_fragment_length));
    kept_now = line_kept_r || keep;

    if (lines_per_record inside {[LPR_MIN:LPR_MAX]}) begin
      per = lines_per_record;
    end else if (lines_per_record < LPR_MIN) begin
      per = LPR_MIN;
    end else begin
      per = LPR_MAX;
    end
    phase_inc = LPR_W'(line_phase_r) + 3'd1;

    kept_sum = SUM_W'(kept_bases_r) + SUM_W'(frag_len_r);
    line_sum = SUM_W'(line_bases_r) + SUM_W'(line_len_r);

    line_phase_nxt = line_phase_r;
    frag_len_nxt   = frag_len_r;
    line_len_nxt   = line_len_r;
    line_kept_nxt  = line_kept_r;
    store_ptr_nxt  = store_ptr_r;
    reads_nxt      = reads_r;
    useful_nxt     = useful_r;
    frags_nxt      = frags_r;
    kept_bases_nxt = kept_bases_r;
    line_bases_nxt = line_bases_r;
    longest_nxt    = longest_r;

    result = '0;

    if (seq_line) begin
      if (cls.hit) begin
        result.write_valid = 1'b1;
        result.write_index = INDEX_W'(64'(store_ptr_r));
        result.write_class = cls.cls;
        store_ptr_nxt      = store_ptr_r + 1'b1;
        frag_len_nxt       = (frag_len_r == CTOP) ? CTOP : frag_len_r + 1'b1;
      end else begin
        if (keep) begin
          result.write_valid = 1'b1;
          result.write_index = INDEX_W'(64'(store_ptr_r));
          result.write_class = CLASS_TERM;
          store_ptr_nxt      = store_ptr_r + 1'b1;
          frags_nxt          = (frags_r == CTOP) ? CTOP : frags_r + 1'b1;
          kept_bases_nxt     = (kept_sum > SUM_W'(BTOP)) ? BTOP : kept_sum[BB-1:0];
          if (frag_len_r > longest_r) begin
            longest_nxt = frag_len_r;
          end
          line_kept_nxt = 1'b1;
        end else begin
          store_ptr_nxt = store_ptr_r - frag_len_r;
        end
        frag_len_nxt = '0;
      end
      if (newline) begin
        reads_nxt = (reads_r == CTOP) ? CTOP : reads_r + 1'b1;
        if (kept_now) begin
          useful_nxt = (useful_r == CTOP) ? CTOP : useful_r + 1'b1;
        end
        line_bases_nxt = (line_sum > SUM_W'(BTOP)) ? BTOP : line_sum[BB-1:0];
        line_len_nxt   = '0;
        line_kept_nxt  = 1'b0;
      end else begin
        line_len_nxt = (line_len_r == CTOP) ? CTOP : line_len_r + 1'b1;
      end
    end

    if (newline) begin
      line_phase_nxt = (phase_inc >= per) ? 2'd0 : phase_inc[1:0];
    end

    longest_inc = (CB + 1)'(longest_nxt) + 1'b1;

    result.read_total         = TOTAL_W'(64'(reads_nxt));
    result.useful_read_total  = TOTAL_W'(64'(useful_nxt));
    result.fragment_total     = TOTAL_W'(64'(frags_nxt));
    result.useable_base_total = BTOTAL_W'(64'(kept_bases_nxt));
    result.base_total         = BTOTAL_W'(64'(line_bases_nxt));
    result.longest_plus_one   = LONGEST_W'(64'(longest_inc));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_phase_r <= '0;
      frag_len_r   <= '0;
      line_len_r   <= '0;
      line_kept_r  <= 1'b0;
      store_ptr_r  <= '0;
      reads_r      <= '0;
      useful_r     <= '0;
      frags_r      <= '0;
      kept_bases_r <= '0;
      line_bases_r <= '0;
      longest_r    <= '0;
    end else if (step_en) begin
      line_phase_r <= line_phase_nxt;
      frag_len_r   <= frag_len_nxt;
      line_len_r   <= line_len_nxt;
      line_kept_r  <= line_kept_nxt;
      store_ptr_r  <= store_ptr_nxt;
      reads_r      <= reads_nxt;
      useful_r     <= useful_nxt;
      frags_r      <= frags_nxt;
      kept_bases_r <= kept_bases_nxt;
      line_bases_r <= line_bases_nxt;
      longest_r    <= longest_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/fastx_fragment_scanner.sv
// top level of the fastx fragment scanner: input register, result register,
// configuration registers and stream handshakes
// depends on ffs_pkg and ffs_engine
//
//  channel  dir  handshake          payload
//  in_      in   in_tvalid/tready   tdata[7:0] file_byte
//  out_     out  out_tvalid/tready  tuser write_valid, tdata packed result fields
//  cfg_     in   cfg_valid/ready    cfg_index register, cfg_data value
//
// one byte per cycle sustained while the result is not stalled; each byte passes through the input register
// and then the result register
// the scanner state updates when a byte moves from the input to the result register
// a stalled result holds the input register; in_tready then drops
// synchronous active-low reset clears state; configuration registers return to their defaults
`timescale 1ns / 1ps
`default_nettype none

module fastx_fragment_scanner #(
  parameter int COUNT_BITS      = ffs_pkg::DEF_COUNT_BITS,
  parameter int BASE_COUNT_BITS = ffs_pkg::DEF_BASE_COUNT_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output      logic                             in_tready,
  input  wire logic [ffs_pkg::BYTE_W-1:0]       in_tdata,   // file_byte
  output      logic                             out_tvalid,
  input  wire logic                             out_tready,
  // write_index, write_class, read_total, useful_read_total, fragment_total,
  // useable_base_total, base_total, longest_plus_one, zero pad
  output      logic [ffs_pkg::OUT_DATA_W-1:0]   out_tdata,
  output      logic                             out_tuser,  // write_valid
  input  wire logic                             cfg_valid,
  output      logic                             cfg_ready,
  input  wire logic [ffs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ffs_pkg::MINLEN_W-1:0]     cfg_data
);
  import ffs_pkg::*;

  logic                in_valid_r;
  logic [BYTE_W-1:0]   in_byte_r;
  logic                out_valid_r;
  ffs_result_t         out_r;
  ffs_result_t         step_result;
  logic                advance;
  logic [LPR_W-1:0]    lines_per_record_r;
  logic [MINLEN_W-1:0] min_frag_len_r;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  ffs_engine #(
    .COUNT_BITS      (COUNT_BITS),
    .BASE_COUNT_BITS (BASE_COUNT_BITS)
  ) u_engine (
    .clk                 (clk),
    .rst_n               (rst_n),
    .step_en             (advance),
    .file_byte           (in_byte_r),
    .lines_per_record    (lines_per_record_r),
    .min_fragment_length (min_frag_len_r),
    .result              (step_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r         <= 1'b0;
      out_valid_r        <= 1'b0;
      lines_per_record_r <= LPR_RESET;
      min_frag_len_r     <= MINLEN_RESET;
    end else begin
      if (in_tvalid && in_tready) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LINES_PER_RECORD:    lines_per_record_r <= cfg_data[LPR_W-1:0];
          CFG_MIN_FRAGMENT_LENGTH: min_frag_len_r     <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
    if (advance) begin
      out_r <= step_result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.write_valid;
  assign out_tdata  = {{OUT_PAD_W{1'b0}},
                       out_r.longest_plus_one,
                       out_r.base_total,
                       out_r.useable_base_total,
                       out_r.fragment_total,
                       out_r.useful_read_total,
                       out_r.read_total,
                       out_r.write_class,
                       out_r.write_index};

  // a held result must block the input register
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input accepted while result stalled");

  // no write means zero index and class
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.write_valid) |->
      (out_r.write_index == '0 && out_r.write_class == CLASS_TERM))
    else $error("write fields set without a write");

  // written class is one of the five codes
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.write_valid) |-> (out_r.write_class <= CLASS_T))
    else $error("write class out of range");

  // a result taken with nothing behind it leaves the output empty
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tready && !in_valid_r) |=> !out_valid_r)
    else $error("result beat repeated");

endmodule

`default_nettype wire
